>>> design/twqc_pkg.sv
// Types and constants for the tail write queue commit unit.
// No dependencies; imported by the interfaces and the top level.
package twqc_pkg;

  localparam logic [1:0] REQ_PUSH       = 2'd0;
  localparam logic [1:0] REQ_COMMIT_NUM = 2'd1;
  localparam logic [1:0] REQ_COMMIT_CMD = 2'd2;
  localparam logic [1:0] REQ_UNUSED     = 2'd3;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [1:0]  ring;
    logic [31:0] tail_value;
    logic [31:0] entry_commands;
    logic [5:0]  pop_count;
    logic [31:0] req_commands;
  } twqc_req_t;

  typedef struct packed {
    logic        status;
    logic        shadow_valid;
    logic [31:0] shadow_tail;
    logic [5:0]  moved;
    logic [31:0] committed_commands;
    logic [5:0]  queue_length;
  } twqc_rsp_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK,
    ST_SHADOW,
    ST_SHWAIT,
    ST_FIN
  } twqc_state_t;

endpackage

>>> design/twqc_if.sv
// Request and response channel interfaces: valid/ready with a struct payload.
// Depends on twqc_pkg.
interface twqc_req_if import twqc_pkg::*; ();
  logic      valid;
  logic      ready;
  twqc_req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface twqc_rsp_if import twqc_pkg::*; ();
  logic      valid;
  logic      ready;
  twqc_rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> design/tail_write_queue_commit_unit.sv
// Tail write queue commit unit: per-ring circular queues with push and batched commit.
// Depends on twqc_pkg and the channel interfaces in twqc_if.sv.
//
//   channel | dir | payload     | accepted when
//   req     | in  | twqc_req_t  | req.valid && req.ready
//   rsp     | out | twqc_rsp_t  | rsp.valid && rsp.ready
//
// After reset a clearing pass writes zero to all RINGS*ENTRIES slots, one per cycle,
// and req.ready stays low until the pass is done.
// Push, unused type, out-of-range ring: ST_FIN loads the response register when free.
// Commits: ST_WALK reads n entries (n up to ENTRIES-1), one entry per cycle, through
// the single read port of the slot memory; ST_SHADOW moves the head and reads the new
// shadow tail, skipped for a zero-sum commit by commands; ST_SHWAIT feeds ST_FIN.
// A waiting response holds in its register; a new request is taken meanwhile and its
// response holds the final state, with req.ready low, until the register frees.
module tail_write_queue_commit_unit import twqc_pkg::*; #(
  parameter int ENTRIES = 64,
  parameter int RINGS   = 4
) (
  input  logic       clk,
  input  logic       rst,
  twqc_req_if.sink   req,
  twqc_rsp_if.source rsp
);

  localparam int SW    = $clog2(ENTRIES);
  localparam int RW    = (RINGS > 1) ? $clog2(RINGS) : 1;
  localparam int DEPTH = RINGS * ENTRIES;
  localparam int AW    = $clog2(DEPTH);

  twqc_state_t state, state_next;

  logic [SW-1:0] head_index [RINGS];
  logic [SW-1:0] tail_index [RINGS];

  logic [31:0] tail_mem [DEPTH];
  logic [31:0] cmd_mem  [DEPTH];
  logic [31:0] tail_rdata, cmd_rdata;

  logic [AW-1:0] clr, clr_next;
  logic          rd_valid, rd_valid_next;
  logic          out_valid, out_valid_next;
  twqc_rsp_t     out_item, out_item_next;

  logic [RW-1:0] rsel, rsel_next;
  logic [SW-1:0] head, head_next;
  logic [SW-1:0] len, len_next;
  logic [SW-1:0] walk_len, walk_len_next;
  logic [SW-1:0] issued, issued_next;
  logic [SW-1:0] slot, slot_next;
  logic [SW-1:0] cnt, cnt_next;
  logic [31:0]   acc, acc_next;
  logic [31:0]   rcmd, rcmd_next;
  logic          is_num, is_num_next;
  twqc_rsp_t     res, res_next;

  logic          mem_we;
  logic [AW-1:0] mem_wa;
  logic [31:0]   mem_wtail, mem_wcmd;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          head_we, tail_we;
  logic [SW-1:0] idx_wdata;

  logic          ring_ok;
  logic [RW-1:0] in_rsel;
  logic [SW-1:0] in_hd, in_tl, in_len, in_nt;
  logic [SW:0]   diff, hsum;
  logic [SW-1:0] new_head;

  function automatic logic [SW-1:0] incr(input logic [SW-1:0] s);
    incr = (s == SW'(ENTRIES - 1)) ? '0 : s + 1'b1;
  endfunction

  function automatic logic [AW-1:0] addr(input logic [RW-1:0] r, input logic [SW-1:0] s);
    addr = AW'(int'(r) * ENTRIES + int'(s));
  endfunction

  assign ring_ok = (int'(req.data.ring) < RINGS);
  assign in_rsel = RW'(req.data.ring);
  assign in_hd   = head_index[in_rsel];
  assign in_tl   = tail_index[in_rsel];
  assign diff    = {1'b0, in_tl} - {1'b0, in_hd};
  assign in_len  = (in_tl >= in_hd) ? diff[SW-1:0] : SW'(diff + (SW+1)'(ENTRIES));
  assign in_nt   = incr(in_tl);
  assign hsum    = {1'b0, head} + {1'b0, cnt};
  assign new_head = (hsum >= (SW+1)'(ENTRIES)) ? SW'(hsum - (SW+1)'(ENTRIES)) : hsum[SW-1:0];

  assign req.ready = (state == ST_IDLE);
  assign rsp.valid = out_valid;
  assign rsp.data  = out_item;

  always_comb begin
    state_next     = state;
    clr_next       = clr;
    rd_valid_next  = 1'b0;
    out_valid_next = out_valid && !rsp.ready;
    out_item_next  = out_item;
    rsel_next      = rsel;
    head_next      = head;
    len_next       = len;
    walk_len_next  = walk_len;
    issued_next    = issued;
    slot_next      = slot;
    cnt_next       = cnt;
    acc_next       = acc;
    rcmd_next      = rcmd;
    is_num_next    = is_num;
    res_next       = res;
    mem_we         = 1'b0;
    mem_wa         = clr;
    mem_wtail      = '0;
    mem_wcmd       = '0;
    rd_en          = 1'b0;
    rd_addr        = addr(rsel, slot);
    head_we        = 1'b0;
    tail_we        = 1'b0;
    idx_wdata      = new_head;

    case (state)
      ST_CLEAR: begin
        mem_we   = 1'b1;
        clr_next = clr + 1'b1;
        if (clr == AW'(DEPTH - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (req.valid) begin
          rsel_next   = in_rsel;
          head_next   = in_hd;
          len_next    = in_len;
          slot_next   = in_hd;
          issued_next = '0;
          cnt_next    = '0;
          acc_next    = '0;
          rcmd_next   = req.data.req_commands;
          res_next    = '0;
          state_next  = ST_FIN;
          if (ring_ok) begin
            res_next.queue_length = 6'(in_len);
            case (req.data.req_type)
              REQ_PUSH: begin
                if (in_nt == in_hd) begin
                  res_next.status = 1'b1;
                end else begin
                  mem_we    = 1'b1;
                  mem_wa    = addr(in_rsel, in_nt);
                  mem_wtail = req.data.tail_value;
                  mem_wcmd  = req.data.entry_commands;
                  tail_we   = 1'b1;
                  idx_wdata = in_nt;
                  res_next.queue_length = 6'(in_len + 1'b1);
                end
              end
              REQ_COMMIT_NUM: begin
                is_num_next   = 1'b1;
                walk_len_next = (16'(req.data.pop_count) > 16'(in_len)) ?
                                in_len : SW'(req.data.pop_count);
                state_next    = ST_WALK;
              end
              REQ_COMMIT_CMD: begin
                is_num_next   = 1'b0;
                walk_len_next = in_len;
                state_next    = ST_WALK;
              end
              default: begin
              end
            endcase
          end
        end
      end
      ST_WALK: begin
        if (rd_valid && (is_num || acc <= rcmd)) begin
          acc_next = acc + cmd_rdata;
          cnt_next = cnt + 1'b1;
        end
        if (issued != walk_len) begin
          slot_next     = incr(slot);
          rd_en         = 1'b1;
          rd_addr       = addr(rsel, incr(slot));
          issued_next   = issued + 1'b1;
          rd_valid_next = 1'b1;
        end else if (!rd_valid) begin
          state_next = ST_SHADOW;
        end
      end
      ST_SHADOW: begin
        if (is_num || acc != '0) begin
          head_we    = 1'b1;
          rd_en      = 1'b1;
          rd_addr    = addr(rsel, new_head);
          len_next   = len - cnt;
          state_next = ST_SHWAIT;
        end else begin
          state_next = ST_FIN;
        end
      end
      ST_SHWAIT: begin
        res_next.shadow_valid       = 1'b1;
        res_next.shadow_tail        = tail_rdata;
        res_next.moved              = 6'(cnt);
        res_next.committed_commands = acc;
        res_next.queue_length       = 6'(len);
        state_next                  = ST_FIN;
      end
      ST_FIN: begin
        if (!out_valid || rsp.ready) begin
          out_valid_next = 1'b1;
          out_item_next  = res;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr       <= '0;
      rd_valid  <= 1'b0;
      out_valid <= 1'b0;
      for (int i = 0; i < RINGS; i++) begin
        head_index[i] <= '0;
        tail_index[i] <= '0;
      end
    end else begin
      state     <= state_next;
      clr       <= clr_next;
      rd_valid  <= rd_valid_next;
      out_valid <= out_valid_next;
      if (head_we) begin
        head_index[rsel] <= idx_wdata;
      end
      if (tail_we) begin
        tail_index[in_rsel] <= idx_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_item <= out_item_next;
    rsel     <= rsel_next;
    head     <= head_next;
    len      <= len_next;
    walk_len <= walk_len_next;
    issued   <= issued_next;
    slot     <= slot_next;
    cnt      <= cnt_next;
    acc      <= acc_next;
    rcmd     <= rcmd_next;
    is_num   <= is_num_next;
    res      <= res_next;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      tail_mem[mem_wa] <= mem_wtail;
      cmd_mem[mem_wa]  <= mem_wcmd;
    end
    if (rd_en) begin
      tail_rdata <= tail_mem[rd_addr];
      cmd_rdata  <= cmd_mem[rd_addr];
    end
  end

`ifndef SYNTHESIS
  a_issue_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WALK) |-> (issued <= walk_len && cnt <= issued))
    else $error("walk issued more reads than its length");

  a_num_count: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SHADOW && is_num) |-> (cnt == walk_len))
    else $error("commit by number popped a wrong count");

  a_no_write_walk: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WALK || state == ST_SHADOW || state == ST_SHWAIT) |-> !mem_we)
    else $error("slot write during a commit");

  a_shwait_order: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SHWAIT) |-> ($past(state) == ST_SHADOW && $past(head_we)))
    else $error("shadow read without head update");
`endif

endmodule

>>> sim/tb.sv
// Testbench for tail_write_queue_commit_unit: directed, back-pressure and random request traffic.
// Depends on twqc_pkg and the channel interfaces in design/twqc_if.sv; predicts every
// response with its own copy of the per-ring queues and checks each one field by field.
module tb;
  import twqc_pkg::*;

  localparam int ENTRIES     = 64;
  localparam int RINGS       = 4;
  localparam int RANDOM_REQS = 1100;
  localparam int LONG_HOLD   = 300;
  localparam int QUIET_LIMIT = 5000;
  localparam int TAIL_CYCLES = 12;

  logic clk;
  logic rst;

  twqc_req_if req_ch ();
  twqc_rsp_if rsp_ch ();

  tail_write_queue_commit_unit #(
    .ENTRIES(ENTRIES),
    .RINGS  (RINGS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  // predicted queue contents
  logic [31:0] slot_tail [RINGS*ENTRIES];
  logic [31:0] slot_cmds [RINGS*ENTRIES];
  int          head_slot [RINGS];
  int          tail_slot [RINGS];

  twqc_rsp_t expected_rsps [$];

  int  n_errors;
  int  n_checked;
  int  n_requests;
  int  n_full_refusals;
  int  n_commits;
  int  quiet_cycles;
  bit  idle_on;
  bit  hold_off_pending;

  initial begin
    clk = 1'b0;
  end

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int occupancy(input int r);
    if (tail_slot[r] >= head_slot[r]) return tail_slot[r] - head_slot[r];
    return tail_slot[r] + ENTRIES - head_slot[r];
  endfunction

  function automatic logic [31:0] drain_entries(input int r, input int n);
    logic [31:0] sum;
    int          slot;
    sum  = '0;
    slot = head_slot[r];
    for (int i = 0; i < n; i++) begin
      slot = (slot + 1) % ENTRIES;
      sum  = sum + slot_cmds[r*ENTRIES + slot];
    end
    head_slot[r] = slot;
    return sum;
  endfunction

  function automatic twqc_rsp_t apply_request(input twqc_req_t q);
    twqc_rsp_t   o;
    int          r;
    int          base;
    int          len;
    int          slot;
    int          cnt;
    logic [31:0] acc;
    o = '0;
    r = int'(q.ring);
    if (r >= RINGS) return o;
    base = r * ENTRIES;
    len  = occupancy(r);
    case (q.req_type)
      REQ_PUSH: begin
        slot = (tail_slot[r] + 1) % ENTRIES;
        if (slot == head_slot[r]) begin
          o.status = 1'b1;
          n_full_refusals++;
        end else begin
          slot_tail[base + slot] = q.tail_value;
          slot_cmds[base + slot] = q.entry_commands;
          tail_slot[r]           = slot;
        end
      end
      REQ_COMMIT_NUM: begin
        cnt = (int'(q.pop_count) > len) ? len : int'(q.pop_count);
        o.committed_commands = drain_entries(r, cnt);
        o.moved              = 6'(cnt);
        o.shadow_valid       = 1'b1;
        o.shadow_tail        = slot_tail[base + head_slot[r]];
        n_commits++;
      end
      REQ_COMMIT_CMD: begin
        acc  = '0;
        cnt  = 0;
        slot = head_slot[r];
        for (int i = 0; i < len; i++) begin
          slot = (slot + 1) % ENTRIES;
          if (acc <= q.req_commands) begin
            acc = acc + slot_cmds[base + slot];
            cnt++;
          end
        end
        if (acc != '0) begin
          void'(drain_entries(r, cnt));
          o.moved              = 6'(cnt);
          o.committed_commands = acc;
          o.shadow_valid       = 1'b1;
          o.shadow_tail        = slot_tail[base + head_slot[r]];
        end
        n_commits++;
      end
      default: ;
    endcase
    o.queue_length = 6'(occupancy(r));
    return o;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (n_errors < 40)
      $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
    n_errors++;
  endtask

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [31:0] rand_entry_commands();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll < 2) return '0;
    if (roll < 6) return $urandom_range(1, 20);
    if (roll < 8) return $urandom;
    if (roll == 8) return 32'hFFFF_FFFF - $urandom_range(0, 3);
    return $urandom_range(0, 255);
  endfunction

  function automatic logic [31:0] rand_budget();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return '0;
    if (roll == 1) return 32'hFFFF_FFFF;
    if (roll < 7) return $urandom_range(0, 60);
    return $urandom;
  endfunction

  // offer one request, wait for the handshake, then record its predicted response
  task automatic send_request(input twqc_req_t item);
    int gap;
    gap = idle_on ? pick_gap() : 0;
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.data  <= item;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    n_requests++;
    expected_rsps.push_back(apply_request(item));
  endtask

  task automatic send_fields(input logic [1:0] kind, input logic [1:0] ring,
                             input logic [31:0] tval, input logic [31:0] cmds,
                             input logic [5:0] count, input logic [31:0] budget);
    twqc_req_t item;
    item.req_type       = kind;
    item.ring           = ring;
    item.tail_value     = tval;
    item.entry_commands = cmds;
    item.pop_count      = count;
    item.req_commands   = budget;
    send_request(item);
  endtask

  task automatic push_entry(input logic [1:0] ring, input logic [31:0] tval,
                            input logic [31:0] cmds);
    send_fields(REQ_PUSH, ring, tval, cmds, 6'($urandom), $urandom);
  endtask

  task automatic commit_number(input logic [1:0] ring, input logic [5:0] count);
    send_fields(REQ_COMMIT_NUM, ring, $urandom, $urandom, count, $urandom);
  endtask

  task automatic commit_commands(input logic [1:0] ring, input logic [31:0] budget);
    send_fields(REQ_COMMIT_CMD, ring, $urandom, $urandom, 6'($urandom), budget);
  endtask

  task automatic wait_until_drained();
    req_ch.valid <= 1'b0;
    while (expected_rsps.size() != 0) @(posedge clk);
  endtask

  task automatic test_corner_requests();
    commit_number(2'd0, 6'd5);
    commit_commands(2'd0, 32'hFFFF_FFFF);
    send_fields(REQ_UNUSED, 2'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd63, 32'hFFFF_FFFF);
    push_entry(2'd0, 32'hFFFF_FFFF, 32'h0);
    push_entry(2'd0, 32'h0, 32'h0);
    commit_commands(2'd0, 32'h0);
    push_entry(2'd0, 32'h1234_5678, 32'hFFFF_FFFF);
    push_entry(2'd0, 32'h0000_000A, 32'd2);
    push_entry(2'd0, 32'h8000_0001, 32'd5);
    commit_commands(2'd0, 32'h0);
    commit_commands(2'd0, 32'hFFFF_FFFF);
    push_entry(2'd1, 32'hDEAD_BEEF, 32'hFFFF_FFFF);
    push_entry(2'd1, 32'h0000_0001, 32'd1);
    push_entry(2'd1, 32'h7FFF_FFFF, 32'd3);
    commit_number(2'd1, 6'd0);
    commit_commands(2'd1, 32'hFFFF_FFFF);
    push_entry(2'd2, 32'h5555_AAAA, 32'd7);
    push_entry(2'd2, 32'hAAAA_5555, 32'd9);
    commit_number(2'd2, 6'd63);
    commit_number(2'd2, 6'd0);
    send_fields(REQ_UNUSED, 2'd2, 32'h0, 32'h0, 6'd0, 32'h0);
  endtask

  task automatic test_full_queue_backpressure();
    hold_off_pending = 1'b1;
    for (int i = 0; i < ENTRIES + 2; i++)
      push_entry(2'd3, $urandom, rand_entry_commands());
    commit_number(2'd3, 6'd63);
    for (int i = 0; i < 8; i++)
      push_entry(2'd3, $urandom, $urandom_range(0, 3));
    commit_commands(2'd3, 32'd4);
    wait_until_drained();
    for (int i = 0; i < ENTRIES; i++)
      push_entry(2'd3, $urandom, rand_entry_commands());
    commit_commands(2'd3, 32'hFFFF_FFFF);
    commit_number(2'd3, 6'd63);
  endtask

  task automatic test_random_traffic();
    int          push_pct;
    int          hot_ring;
    int          roll;
    logic [1:0]  ring;
    logic [5:0]  count;
    for (int blk = 0; blk < RANDOM_REQS / 100; blk++) begin
      idle_on  = (blk % 4 != 3);
      push_pct = $urandom_range(30, 80);
      hot_ring = $urandom_range(0, RINGS - 1);
      for (int i = 0; i < 100; i++) begin
        ring = ($urandom_range(0, 9) < 6) ? 2'(hot_ring) : 2'($urandom);
        roll = $urandom_range(0, 99);
        if (roll < 2) begin
          send_fields(REQ_UNUSED, ring, $urandom, $urandom, 6'($urandom), $urandom);
        end else if (roll < push_pct) begin
          push_entry(ring, $urandom, rand_entry_commands());
        end else if (roll % 2 == 0) begin
          count = ($urandom_range(0, 6) == 0) ? 6'($urandom) : 6'($urandom_range(0, 7));
          commit_number(ring, count);
        end else begin
          commit_commands(ring, rand_budget());
        end
      end
    end
    idle_on = 1'b1;
  endtask

  // response sink: random stalls, plus one long hold-off on request
  initial begin : rsp_sink
    int stall;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_pending) begin
        rsp_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_off_pending = 1'b0;
        rsp_ch.ready <= 1'b1;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        stall = 1 + pick_gap();
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
        rsp_ch.ready <= 1'b1;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : rsp_check
    twqc_rsp_t got;
    twqc_rsp_t want;
    if (!rst && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
      got = rsp_ch.data;
      if (expected_rsps.size() == 0) begin
        report_mismatch("unexpected response", 32'({got.status, got.shadow_valid, got.moved,
                        got.queue_length}), '0);
      end else begin
        want = expected_rsps.pop_front();
        n_checked++;
        if (got.status !== want.status)
          report_mismatch("status", 32'(got.status), 32'(want.status));
        if (got.shadow_valid !== want.shadow_valid)
          report_mismatch("shadow_valid", 32'(got.shadow_valid), 32'(want.shadow_valid));
        if (got.shadow_tail !== want.shadow_tail)
          report_mismatch("shadow_tail", got.shadow_tail, want.shadow_tail);
        if (got.moved !== want.moved)
          report_mismatch("moved", 32'(got.moved), 32'(want.moved));
        if (got.committed_commands !== want.committed_commands)
          report_mismatch("committed_commands", got.committed_commands,
                          want.committed_commands);
        if (got.queue_length !== want.queue_length)
          report_mismatch("queue_length", 32'(got.queue_length), 32'(want.queue_length));
      end
    end
  end

  always @(posedge clk) begin
    if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
        (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles, %0d responses outstanding",
                 quiet_cycles, expected_rsps.size());
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    for (int i = 0; i < RINGS*ENTRIES; i++) begin
      slot_tail[i] = '0;
      slot_cmds[i] = '0;
    end
    for (int r = 0; r < RINGS; r++) begin
      head_slot[r] = 0;
      tail_slot[r] = 0;
    end
    n_errors         = 0;
    n_checked        = 0;
    n_requests       = 0;
    n_full_refusals  = 0;
    n_commits        = 0;
    quiet_cycles     = 0;
    idle_on          = 1'b1;
    hold_off_pending = 1'b0;
    rst          <= 1'b1;
    req_ch.valid <= 1'b0;
    req_ch.data  <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_corner_requests();
    test_full_queue_backpressure();
    test_random_traffic();

    wait_until_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Run covered %0d requests: %0d commits, %0d pushes refused on a full queue.",
             n_requests, n_commits, n_full_refusals);
    $display("Responses compared: %0d, mismatches: %0d.", n_checked, n_errors);
    if (n_errors == 0 && expected_rsps.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
